// ----- rtl/sllt_pkg.sv -----
package sllt_pkg;

    // Pool size default
    localparam int SLOTS_DEF = 64;

    // Field widths of the stream words
    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 32;
    localparam int SLOT_O_W  = 6;
    localparam int COUNT_O_W = 7;
    localparam int OUT_W     = 1 + SLOT_O_W + 1 + SLOT_O_W + COUNT_O_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Operation codes carried on tuser
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    // Result of one request, already cut to the output field widths
    typedef struct packed {
        logic [COUNT_O_W-1:0] entries;
        logic [SLOT_O_W-1:0]  prev_slot;
        logic                 prev_valid;
        logic [SLOT_O_W-1:0]  slot;
        logic                 ok;
    } t_result;

endpackage

// ----- rtl/sorted_linked_list_table_top.sv -----
// A request walks the list entries with one read per cycle, then passes S_ACT, the link
// updates (S_INS1, S_INS2 or S_DEL2) where needed, and S_OUT before its result word is given.
// Throughput: one request at a time; no new request is taken until the last one is done.
// The result word sits in an output register, so the next word is taken while it waits.
// Reset: synchronous, active low; afterwards an init pass over every slot rebuilds the free
// chain in the link memory, and no word is taken until it ends.
module sorted_linked_list_table_top import sllt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [KEY_W-1:0]       i_s_tdata,   // key
    input  logic [FUNC_W-1:0]      i_s_tuser,   // func
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // ok, slot, prev_valid, prev_slot, entries
);

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);

    logic          w_done;
    t_result       w_result;
    logic [SW-1:0] w_raddr;
    logic [KEY_W-1:0] w_key_rdata;
    logic [LW-1:0] w_link_rdata;
    logic          w_key_we;
    logic [SW-1:0] w_key_waddr;
    logic [KEY_W-1:0] w_key_wdata;
    logic          w_link_we;
    logic [SW-1:0] w_link_waddr;
    logic [LW-1:0] w_link_wdata;

    logic          r_ovalid;
    t_result       r_odata;

    sllt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .o_req_ready  (o_s_tready),
        .i_req_func   (i_s_tuser),
        .i_req_key    (i_s_tdata),
        .i_out_free   (!r_ovalid || i_m_tready),
        .o_done       (w_done),
        .o_result     (w_result),
        .o_raddr      (w_raddr),
        .i_key_rdata  (w_key_rdata),
        .i_link_rdata (w_link_rdata),
        .o_key_we     (w_key_we),
        .o_key_waddr  (w_key_waddr),
        .o_key_wdata  (w_key_wdata),
        .o_link_we    (w_link_we),
        .o_link_waddr (w_link_waddr),
        .o_link_wdata (w_link_wdata)
    );

    // key store
    sllt_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (w_key_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_key_rdata)
    );

    // next links, list and free chain
    sllt_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_link_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_odata <= w_result;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OUT_TDATA_W'(r_odata);

endmodule

// ----- rtl/sllt_ram.sv -----
module sllt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sllt_ctrl.sv -----
module sllt_ctrl import sllt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request side
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  logic [FUNC_W-1:0]          i_req_func,
    input  logic [KEY_W-1:0]           i_req_key,
    // result side
    input  logic                       i_out_free,
    output logic                       o_done,
    output t_result                    o_result,
    // memory ports
    output logic [$clog2(SLOTS)-1:0]   o_raddr,
    input  logic [KEY_W-1:0]           i_key_rdata,
    input  logic [$clog2(SLOTS+1)-1:0] i_link_rdata,
    output logic                       o_key_we,
    output logic [$clog2(SLOTS)-1:0]   o_key_waddr,
    output logic [KEY_W-1:0]           o_key_wdata,
    output logic                       o_link_we,
    output logic [$clog2(SLOTS)-1:0]   o_link_waddr,
    output logic [$clog2(SLOTS+1)-1:0] o_link_wdata
);

    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_WALK = 8'b0000_0100,
        S_ACT  = 8'b0000_1000,
        S_INS1 = 8'b0001_0000,
        S_INS2 = 8'b0010_0000,
        S_DEL2 = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // control registers
    logic [SW-1:0] r_clr, n_clr;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_count, n_count;
    // per-request registers
    logic [FUNC_W-1:0] r_func, n_func;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [SW-1:0] r_p, n_p;
    logic [SW-1:0] r_prev, n_prev;
    logic          r_pv, n_pv;
    logic [LW-1:0] r_stop, n_stop;
    logic          r_found, n_found;
    logic [LW-1:0] r_hit_next, n_hit_next;
    logic [SW-1:0] r_slot, n_slot;
    logic          r_ok, n_ok;

    logic signed [KEY_W-1:0] w_key_rd;

    assign w_key_rd = i_key_rdata;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_key_waddr = r_slot;
    assign o_key_wdata = r_key;

    // Result word, cut to field widths
    always_comb begin
        o_result.ok         = r_ok;
        o_result.slot       = r_ok ? SLOT_O_W'(r_slot) : '0;
        o_result.prev_valid = r_pv;
        o_result.prev_slot  = r_pv ? SLOT_O_W'(r_prev) : '0;
        o_result.entries    = COUNT_O_W'(r_count);
    end

    // Sequencer: clear pass, list walk, link updates
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_head     = r_head;
        n_free     = r_free;
        n_count    = r_count;
        n_func     = r_func;
        n_key      = r_key;
        n_p        = r_p;
        n_prev     = r_prev;
        n_pv       = r_pv;
        n_stop     = r_stop;
        n_found    = r_found;
        n_hit_next = r_hit_next;
        n_slot     = r_slot;
        n_ok       = r_ok;
        o_raddr      = r_p;
        o_key_we     = 1'b0;
        o_link_we    = 1'b0;
        o_link_waddr = r_clr;
        o_link_wdata = '0;
        o_done       = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // build the free chain: slot i links to i+1
                o_link_we    = 1'b1;
                o_link_waddr = r_clr;
                o_link_wdata = LW'(r_clr) + LW'(1);
                n_clr        = r_clr + SW'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_raddr = r_head[SW-1:0];
                if (i_req_valid) begin
                    n_func  = i_req_func;
                    n_key   = i_req_key;
                    n_pv    = 1'b0;
                    n_prev  = '0;
                    n_found = 1'b0;
                    n_ok    = 1'b0;
                    n_stop  = r_head;
                    n_p     = r_head[SW-1:0];
                    if (i_req_func != FUNC_SEARCH && i_req_func != FUNC_INSERT &&
                        i_req_func != FUNC_DELETE) begin
                        n_state = S_ACT;
                    end else if (r_head == NULL_LINK) begin
                        n_state = S_ACT;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // one list entry per cycle; next address from read data
                if (w_key_rd < r_key) begin
                    n_prev = r_p;
                    n_pv   = 1'b1;
                    if (i_link_rdata == NULL_LINK) begin
                        n_stop  = NULL_LINK;
                        n_state = S_ACT;
                    end else begin
                        o_raddr = i_link_rdata[SW-1:0];
                        n_p     = i_link_rdata[SW-1:0];
                    end
                end else begin
                    n_stop     = LW'(r_p);
                    n_found    = (w_key_rd == r_key);
                    n_slot     = r_p;
                    n_hit_next = i_link_rdata;
                    n_state    = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_OUT;
                if (r_func == FUNC_SEARCH) begin
                    n_ok = r_found;
                end else if (r_func == FUNC_INSERT) begin
                    if (r_free != NULL_LINK && !r_found) begin
                        // fetch the link of the new slot to pop the free chain
                        o_raddr = r_free[SW-1:0];
                        n_slot  = r_free[SW-1:0];
                        n_ok    = 1'b1;
                        n_state = S_INS1;
                    end
                end else if (r_func == FUNC_DELETE) begin
                    if (r_found) begin
                        o_link_we    = 1'b1;
                        o_link_waddr = r_slot;
                        o_link_wdata = r_free;
                        n_free       = LW'(r_slot);
                        n_count      = r_count - LW'(1);
                        n_ok         = 1'b1;
                        if (r_pv) begin
                            n_state = S_DEL2;
                        end else begin
                            n_head = r_hit_next;
                        end
                    end
                end
            end
            S_INS1: begin
                n_free       = i_link_rdata;
                o_key_we     = 1'b1;
                o_link_we    = 1'b1;
                o_link_waddr = r_slot;
                o_link_wdata = r_stop;
                n_count      = r_count + LW'(1);
                if (r_pv) begin
                    n_state = S_INS2;
                end else begin
                    n_head  = LW'(r_slot);
                    n_state = S_OUT;
                end
            end
            S_INS2: begin
                o_link_we    = 1'b1;
                o_link_waddr = r_prev;
                o_link_wdata = LW'(r_slot);
                n_state      = S_OUT;
            end
            S_DEL2: begin
                o_link_we    = 1'b1;
                o_link_waddr = r_prev;
                o_link_wdata = r_hit_next;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_clr   <= '0;
            r_head  <= NULL_LINK;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_p        <= n_p;
        r_prev     <= n_prev;
        r_pv       <= n_pv;
        r_stop     <= n_stop;
        r_found    <= n_found;
        r_hit_next <= n_hit_next;
        r_slot     <= n_slot;
        r_ok       <= n_ok;
    end

endmodule
